// ===== rtl/core/aesi_pkg.sv =====
`timescale 1ns / 1ps
package aesi_pkg;

    localparam int MAX_SEQ_LEN = 75;
    localparam int MAX_ARGS    = 10;
    localparam int FIELD_LIMIT = 10;
    localparam int ARG_W       = 14;
    localparam int QUEUE_DEPTH = 2;

    localparam int SEQ_W     = $clog2(MAX_SEQ_LEN + 1);
    localparam int ARG_CNT_W = $clog2(MAX_ARGS + 1);
    localparam int ARG_IDX_W = $clog2(MAX_ARGS);
    localparam int FIELD_W   = $clog2(FIELD_LIMIT + 1);
    localparam int QPTR_W    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_IDX_W = 2;

    localparam logic [ARG_W-1:0] ARG_SAT = {ARG_W{1'b1}};

    localparam logic [7:0] ATTR_RESET = 8'h07;
    localparam logic [7:0] COLS_RESET = 8'd80;
    localparam logic [7:0] ROWS_RESET = 8'd25;

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_COLUMNS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_ROWS    = 2'd1;

    localparam logic [7:0] CH_ESC      = 8'd27;
    localparam logic [7:0] CH_LBRACKET = 8'h5b;
    localparam logic [7:0] CH_SEMI     = 8'h3b;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_UP       = 8'h41;
    localparam logic [7:0] CH_DOWN     = 8'h42;
    localparam logic [7:0] CH_RIGHT    = 8'h43;
    localparam logic [7:0] CH_LEFT     = 8'h44;
    localparam logic [7:0] CH_POS_H    = 8'h48;
    localparam logic [7:0] CH_POS_F    = 8'h66;
    localparam logic [7:0] CH_SAVE     = 8'h73;
    localparam logic [7:0] CH_RESTORE  = 8'h75;
    localparam logic [7:0] CH_CLS      = 8'h4a;
    localparam logic [7:0] CH_EOL_UC   = 8'h4b;
    localparam logic [7:0] CH_EOL_LC   = 8'h6b;
    localparam logic [7:0] CH_SGR      = 8'h6d;

    localparam logic [2:0] COLOR_MAP [8] = '{3'd0, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7};

    typedef enum logic [1:0] {
        KIND_ABSORB,
        KIND_PRINT,
        KIND_END
    } item_kind_t;

    typedef enum logic [2:0] {
        EV_NONE  = 3'd0,
        EV_PRINT = 3'd1,
        EV_MOVE  = 3'd2,
        EV_CLS   = 3'd3,
        EV_EOL   = 3'd4,
        EV_ATTR  = 3'd5
    } event_t;

    typedef struct packed {
        item_kind_t                       kind;
        logic [7:0]                       chr;
        logic [7:0]                       col;
        logic [7:0]                       row;
        logic [ARG_CNT_W-1:0]             argc;
        logic [MAX_ARGS-1:0][ARG_W-1:0]   args;
    } item_t;

    function automatic logic [7:0] size_hi(input logic [7:0] size);
        return (size == 8'd0) ? 8'd0 : size - 8'd1;
    endfunction

    function automatic logic [7:0] clamp_hi(input logic [ARG_W:0] v, input logic [7:0] hi);
        if (v > (ARG_W+1)'(hi))
            return hi;
        return v[7:0];
    endfunction

    function automatic logic [7:0] apply_sgr(input logic [7:0] at, input logic [ARG_W-1:0] a);
        logic [7:0]       res;
        logic [ARG_W-1:0] off;
        res = at;
        off = '0;
        if (a == ARG_W'(0))
            res = ATTR_RESET;
        else if (a == ARG_W'(1))
            res = at | 8'h08;
        else if (a == ARG_W'(5))
            res = at | 8'h80;
        else if (a == ARG_W'(7))
            res = {at[7], at[2:0], at[3], at[6:4]};
        else if (a == ARG_W'(8))
            res = 8'h00;
        else if (a >= ARG_W'(30) && a <= ARG_W'(37)) begin
            off = a - ARG_W'(30);
            res = (at & 8'hf8) | {5'b0, COLOR_MAP[off[2:0]]};
        end
        else if (a >= ARG_W'(40) && a <= ARG_W'(47)) begin
            off = a - ARG_W'(40);
            res = (at & 8'h8f) | {1'b0, COLOR_MAP[off[2:0]], 4'b0};
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/aesi_front.sv =====
`timescale 1ns / 1ps
module aesi_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [7:0]            in_byte,
    input  logic [7:0]            cursor_col,
    input  logic [7:0]            cursor_row,
    output logic                  push,
    output aesi_pkg::item_t       push_item
);

    logic [aesi_pkg::SEQ_W-1:0]     seq_len_reg, seq_len_next;
    logic                           bracket_reg, bracket_next;
    logic [aesi_pkg::MAX_ARGS-1:0][aesi_pkg::ARG_W-1:0] args_reg, args_next;
    logic [aesi_pkg::ARG_CNT_W-1:0] argc_reg, argc_next;
    logic [aesi_pkg::FIELD_W-1:0]   fchars_reg, fchars_next;
    logic                           nondig_reg, nondig_next;

    logic                           is_digit;
    logic                           ok_char;
    logic                           bad_second;
    logic                           ends;
    logic                           bracket_eff;
    logic [aesi_pkg::ARG_W-1:0]     arg_sel;
    logic [aesi_pkg::ARG_W+3:0]     arg_prod;

    assign push = accept;

    always_comb
    begin
        seq_len_next = seq_len_reg;
        bracket_next = bracket_reg;
        args_next    = args_reg;
        argc_next    = argc_reg;
        fchars_next  = fchars_reg;
        nondig_next  = nondig_reg;

        is_digit    = (in_byte >= aesi_pkg::CH_ZERO) && (in_byte <= aesi_pkg::CH_NINE);
        ok_char     = is_digit || (in_byte == aesi_pkg::CH_LBRACKET) ||
                      (in_byte == aesi_pkg::CH_SEMI);
        bad_second  = (seq_len_reg == aesi_pkg::SEQ_W'(1)) ?
                      (in_byte != aesi_pkg::CH_LBRACKET) : !bracket_reg;
        ends        = !ok_char || bad_second ||
                      (seq_len_reg >= aesi_pkg::SEQ_W'(aesi_pkg::MAX_SEQ_LEN));
        bracket_eff = (seq_len_reg == aesi_pkg::SEQ_W'(1)) ?
                      (in_byte == aesi_pkg::CH_LBRACKET) : bracket_reg;
        arg_sel     = args_reg[argc_reg[aesi_pkg::ARG_IDX_W-1:0]];
        arg_prod    = (aesi_pkg::ARG_W+4)'({arg_sel, 3'b000}) +
                      (aesi_pkg::ARG_W+4)'({arg_sel, 1'b0}) +
                      (aesi_pkg::ARG_W+4)'(in_byte - aesi_pkg::CH_ZERO);

        push_item.kind = aesi_pkg::KIND_ABSORB;
        push_item.chr  = in_byte;
        push_item.col  = cursor_col;
        push_item.row  = cursor_row;
        push_item.argc = argc_reg;
        push_item.args = args_reg;

        if (seq_len_reg != '0)
        begin
            if (!ends)
            begin
                bracket_next = bracket_eff;
                seq_len_next = seq_len_reg + aesi_pkg::SEQ_W'(1);
                if (seq_len_reg >= aesi_pkg::SEQ_W'(2) &&
                    argc_reg < aesi_pkg::ARG_CNT_W'(aesi_pkg::MAX_ARGS) &&
                    fchars_reg < aesi_pkg::FIELD_W'(aesi_pkg::FIELD_LIMIT))
                begin
                    if (in_byte == aesi_pkg::CH_SEMI)
                    begin
                        argc_next   = argc_reg + aesi_pkg::ARG_CNT_W'(1);
                        fchars_next = '0;
                        nondig_next = 1'b0;
                    end
                    else
                    begin
                        fchars_next = fchars_reg + aesi_pkg::FIELD_W'(1);
                        if (is_digit && !nondig_reg)
                        begin
                            if (arg_prod > (aesi_pkg::ARG_W+4)'(aesi_pkg::ARG_SAT))
                                args_next[argc_reg[aesi_pkg::ARG_IDX_W-1:0]] = aesi_pkg::ARG_SAT;
                            else
                                args_next[argc_reg[aesi_pkg::ARG_IDX_W-1:0]] =
                                    arg_prod[aesi_pkg::ARG_W-1:0];
                        end
                        else
                            nondig_next = 1'b1;
                    end
                end
            end
            else
            begin
                if (bracket_eff)
                begin
                    push_item.kind = aesi_pkg::KIND_END;
                    if (fchars_reg != '0 &&
                        argc_reg < aesi_pkg::ARG_CNT_W'(aesi_pkg::MAX_ARGS))
                        push_item.argc = argc_reg + aesi_pkg::ARG_CNT_W'(1);
                end
                seq_len_next = '0;
                bracket_next = 1'b0;
                args_next    = '0;
                argc_next    = '0;
                fchars_next  = '0;
                nondig_next  = 1'b0;
            end
        end
        else if (in_byte == aesi_pkg::CH_ESC)
        begin
            seq_len_next = aesi_pkg::SEQ_W'(1);
            bracket_next = 1'b0;
            args_next    = '0;
            argc_next    = '0;
            fchars_next  = '0;
            nondig_next  = 1'b0;
        end
        else
            push_item.kind = aesi_pkg::KIND_PRINT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_len_reg <= '0;
            bracket_reg <= 1'b0;
            args_reg    <= '0;
            argc_reg    <= '0;
            fchars_reg  <= '0;
            nondig_reg  <= 1'b0;
        end
        else if (accept)
        begin
            seq_len_reg <= seq_len_next;
            bracket_reg <= bracket_next;
            args_reg    <= args_next;
            argc_reg    <= argc_next;
            fchars_reg  <= fchars_next;
            nondig_reg  <= nondig_next;
        end
    end

endmodule

// ===== rtl/core/aesi_queue.sv =====
`timescale 1ns / 1ps
module aesi_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  aesi_pkg::item_t    push_item,
    output logic               full,
    input  logic               pop,
    output aesi_pkg::item_t    head,
    output logic               empty
);

    aesi_pkg::item_t                entry_mem [aesi_pkg::QUEUE_DEPTH];
    logic [aesi_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [aesi_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [aesi_pkg::QCNT_W-1:0]    count_reg, count_next;
    logic                           do_push;
    logic                           do_pop;

    assign full    = (count_reg == aesi_pkg::QCNT_W'(aesi_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == aesi_pkg::QPTR_W'(aesi_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + aesi_pkg::QPTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == aesi_pkg::QPTR_W'(aesi_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + aesi_pkg::QPTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + aesi_pkg::QCNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - aesi_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_mem[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/core/aesi_back.sv =====
`timescale 1ns / 1ps
module aesi_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         screen_columns,
    input  logic [7:0]         screen_rows,
    input  aesi_pkg::item_t    head,
    input  logic               empty,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         event_res,
    output logic [7:0]         print_char,
    output logic [7:0]         target_col,
    output logic [7:0]         target_row,
    output logic [7:0]         text_attr,
    output logic [7:0]         clear_count
);

    typedef enum logic {
        S_IDLE,
        S_SGR
    } state_t;

    state_t                         state_reg, state_next;
    logic [aesi_pkg::ARG_CNT_W-1:0] k_reg, k_next;
    logic [7:0]                     attr_reg, attr_next;
    logic [15:0]                    saved_reg, saved_next;
    logic                           out_valid_reg, out_valid_next;
    aesi_pkg::event_t               ev_reg, ev_next;
    logic [7:0]                     pch_reg, pch_next;
    logic [7:0]                     tc_reg, tc_next;
    logic [7:0]                     tr_reg, tr_next;
    logic [7:0]                     clr_reg, clr_next;
    logic [7:0]                     attr_out_reg, attr_out_next;

    aesi_pkg::event_t               res_ev;
    logic [7:0]                     res_pch;
    logic [7:0]                     res_tc;
    logic [7:0]                     res_tr;
    logic [7:0]                     res_clr;
    logic                           res_save;

    logic                           out_free;
    logic                           is_sgr;
    logic [7:0]                     cols_hi;
    logic [7:0]                     rows_hi;
    logic [aesi_pkg::ARG_W-1:0]     a0;
    logic [aesi_pkg::ARG_W-1:0]     a1;
    logic [aesi_pkg::ARG_W:0]       col_w;
    logic [aesi_pkg::ARG_W:0]       row_w;
    logic [aesi_pkg::ARG_W:0]       a0_w;

    assign out_free = !out_valid_reg || !out_stall;
    assign is_sgr   = (head.kind == aesi_pkg::KIND_END) && (head.chr == aesi_pkg::CH_SGR);
    assign cols_hi  = aesi_pkg::size_hi(screen_columns);
    assign rows_hi  = aesi_pkg::size_hi(screen_rows);

    always_comb
    begin
        res_ev   = aesi_pkg::EV_NONE;
        res_pch  = 8'd0;
        res_tc   = head.col;
        res_tr   = head.row;
        res_clr  = 8'd0;
        res_save = 1'b0;
        a0       = head.args[0];
        a1       = head.args[1];
        if (head.chr >= aesi_pkg::CH_UP && head.chr <= aesi_pkg::CH_LEFT && a0 == '0)
            a0 = aesi_pkg::ARG_W'(1);
        col_w    = (aesi_pkg::ARG_W+1)'(head.col);
        row_w    = (aesi_pkg::ARG_W+1)'(head.row);
        a0_w     = (aesi_pkg::ARG_W+1)'(a0);

        unique case (head.kind)
            aesi_pkg::KIND_PRINT:
            begin
                res_ev  = aesi_pkg::EV_PRINT;
                res_pch = head.chr;
            end
            aesi_pkg::KIND_END:
            begin
                priority case (head.chr)
                    aesi_pkg::CH_POS_H, aesi_pkg::CH_POS_F:
                    begin
                        res_ev = aesi_pkg::EV_MOVE;
                        res_tc = (a1 == '0) ? 8'd0 : aesi_pkg::clamp_hi(
                                 (aesi_pkg::ARG_W+1)'(a1) - (aesi_pkg::ARG_W+1)'(1), cols_hi);
                        res_tr = (a0 == '0) ? 8'd0 : aesi_pkg::clamp_hi(
                                 a0_w - (aesi_pkg::ARG_W+1)'(1), rows_hi);
                    end
                    aesi_pkg::CH_UP:
                    begin
                        res_ev = aesi_pkg::EV_MOVE;
                        res_tc = aesi_pkg::clamp_hi(col_w, cols_hi);
                        res_tr = (a0_w > row_w) ? 8'd0 :
                                 aesi_pkg::clamp_hi(row_w - a0_w, rows_hi);
                    end
                    aesi_pkg::CH_DOWN:
                    begin
                        res_ev = aesi_pkg::EV_MOVE;
                        res_tc = aesi_pkg::clamp_hi(col_w, cols_hi);
                        res_tr = aesi_pkg::clamp_hi(row_w + a0_w, rows_hi);
                    end
                    aesi_pkg::CH_RIGHT:
                    begin
                        res_ev = aesi_pkg::EV_MOVE;
                        res_tc = aesi_pkg::clamp_hi(col_w + a0_w, cols_hi);
                        res_tr = aesi_pkg::clamp_hi(row_w, rows_hi);
                    end
                    aesi_pkg::CH_LEFT:
                    begin
                        res_ev = aesi_pkg::EV_MOVE;
                        res_tc = (a0_w > col_w) ? 8'd0 :
                                 aesi_pkg::clamp_hi(col_w - a0_w, cols_hi);
                        res_tr = aesi_pkg::clamp_hi(row_w, rows_hi);
                    end
                    aesi_pkg::CH_SAVE:
                        res_save = 1'b1;
                    aesi_pkg::CH_RESTORE:
                    begin
                        res_ev = aesi_pkg::EV_MOVE;
                        res_tc = aesi_pkg::clamp_hi((aesi_pkg::ARG_W+1)'(saved_reg[7:0]),
                                                    cols_hi);
                        res_tr = aesi_pkg::clamp_hi((aesi_pkg::ARG_W+1)'(saved_reg[15:8]),
                                                    rows_hi);
                    end
                    aesi_pkg::CH_CLS:
                    begin
                        if (head.args[0] == aesi_pkg::ARG_W'(2))
                        begin
                            res_ev = aesi_pkg::EV_CLS;
                            res_tc = 8'd0;
                            res_tr = 8'd0;
                        end
                    end
                    aesi_pkg::CH_EOL_UC, aesi_pkg::CH_EOL_LC:
                    begin
                        res_ev  = aesi_pkg::EV_EOL;
                        res_clr = (screen_columns > head.col) ? screen_columns - head.col : 8'd0;
                    end
                    aesi_pkg::CH_SGR:
                        res_ev = aesi_pkg::EV_ATTR;
                    default:
                        res_ev = aesi_pkg::EV_NONE;
                endcase
            end
            default:
                res_ev = aesi_pkg::EV_NONE;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        attr_next      = attr_reg;
        saved_next     = saved_reg;
        out_valid_next = out_valid_reg && out_stall;
        ev_next        = ev_reg;
        pch_next       = pch_reg;
        tc_next        = tc_reg;
        tr_next        = tr_reg;
        clr_next       = clr_reg;
        attr_out_next  = attr_out_reg;
        pop            = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!empty)
                begin
                    if (is_sgr)
                    begin
                        k_next     = '0;
                        state_next = S_SGR;
                        if (head.argc == '0)
                            attr_next = aesi_pkg::ATTR_RESET;
                    end
                    else if (out_free)
                    begin
                        pop            = 1'b1;
                        out_valid_next = 1'b1;
                        ev_next        = res_ev;
                        pch_next       = res_pch;
                        tc_next        = res_tc;
                        tr_next        = res_tr;
                        clr_next       = res_clr;
                        attr_out_next  = attr_reg;
                        if (res_save)
                            saved_next = {head.row, head.col};
                    end
                end
            end
            S_SGR:
            begin
                if (k_reg < head.argc)
                begin
                    attr_next = aesi_pkg::apply_sgr(attr_reg,
                                    head.args[k_reg[aesi_pkg::ARG_IDX_W-1:0]]);
                    k_next    = k_reg + aesi_pkg::ARG_CNT_W'(1);
                end
                else if (out_free)
                begin
                    pop            = 1'b1;
                    out_valid_next = 1'b1;
                    ev_next        = aesi_pkg::EV_ATTR;
                    pch_next       = 8'd0;
                    tc_next        = head.col;
                    tr_next        = head.row;
                    clr_next       = 8'd0;
                    attr_out_next  = attr_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            attr_reg      <= aesi_pkg::ATTR_RESET;
            saved_reg     <= '0;
            out_valid_reg <= 1'b0;
            ev_reg        <= aesi_pkg::EV_NONE;
            pch_reg       <= '0;
            tc_reg        <= '0;
            tr_reg        <= '0;
            clr_reg       <= '0;
            attr_out_reg  <= aesi_pkg::ATTR_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            attr_reg      <= attr_next;
            saved_reg     <= saved_next;
            out_valid_reg <= out_valid_next;
            ev_reg        <= ev_next;
            pch_reg       <= pch_next;
            tc_reg        <= tc_next;
            tr_reg        <= tr_next;
            clr_reg       <= clr_next;
            attr_out_reg  <= attr_out_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign event_res   = ev_reg;
    assign print_char  = pch_reg;
    assign target_col  = tc_reg;
    assign target_row  = tr_reg;
    assign text_attr   = attr_out_reg;
    assign clear_count = clr_reg;

endmodule

// ===== rtl/core/ansi_escape_sequence_interpreter_top.sv =====
`timescale 1ns / 1ps
// Terminal byte interpreter for ESC-bracket cursor, clear and attribute commands. Each accepted
// byte gives exactly one result beat. The front end takes one byte per cycle, while the queue is
// not full (in_stall), into a two-beat queue; the back end drains it, and for an attribute command
// (ESC [ ... m) the single attribute update unit walks the stored arguments one at a time before
// the byte is reported, taking no new byte from the queue meanwhile. text_attr always shows the
// attribute in force after the reported byte. Write the screen size registers only while no byte
// is in flight; a size of zero bounds the cursor as a size of one does.
module ansi_escape_sequence_interpreter_top
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [7:0]                       in_byte,
    input  logic [7:0]                       cursor_col,
    input  logic [7:0]                       cursor_row,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [2:0]                       event_res,
    output logic [7:0]                       print_char,
    output logic [7:0]                       target_col,
    output logic [7:0]                       target_row,
    output logic [7:0]                       text_attr,
    output logic [7:0]                       clear_count,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [aesi_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [7:0]                       cfg_data
);

    logic [7:0]        cols_reg;
    logic [7:0]        rows_reg;
    logic              q_full;
    logic              q_empty;
    logic              q_pop;
    logic              q_push;
    logic              accept;
    aesi_pkg::item_t   q_push_item;
    aesi_pkg::item_t   q_head;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;
    assign accept    = in_valid && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= aesi_pkg::COLS_RESET;
            rows_reg <= aesi_pkg::ROWS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                aesi_pkg::REG_SCREEN_COLUMNS: cols_reg <= cfg_data;
                aesi_pkg::REG_SCREEN_ROWS:    rows_reg <= cfg_data;
                default:                      cols_reg <= cols_reg;
            endcase
        end
    end

    aesi_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .in_byte    (in_byte),
        .cursor_col (cursor_col),
        .cursor_row (cursor_row),
        .push       (q_push),
        .push_item  (q_push_item)
    );

    aesi_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    aesi_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .screen_columns (cols_reg),
        .screen_rows    (rows_reg),
        .head           (q_head),
        .empty          (q_empty),
        .pop            (q_pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .event_res      (event_res),
        .print_char     (print_char),
        .target_col     (target_col),
        .target_row     (target_row),
        .text_attr      (text_attr),
        .clear_count    (clear_count)
    );

    a_move_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res == aesi_pkg::EV_MOVE) |->
            (target_col <= aesi_pkg::size_hi(cols_reg)) &&
            (target_row <= aesi_pkg::size_hi(rows_reg)))
        else $error("cursor move beyond screen");

    a_print_char_only_on_print: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res != aesi_pkg::EV_PRINT) |-> (print_char == 8'd0))
        else $error("print_char set on a non-print beat");

    a_clear_count_only_on_eol: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res != aesi_pkg::EV_EOL) |-> (clear_count == 8'd0))
        else $error("clear_count set on a non-clear beat");

    a_cls_home: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res == aesi_pkg::EV_CLS) |->
            (target_col == 8'd0) && (target_row == 8'd0))
        else $error("clear screen does not home the cursor");

endmodule
